>>> hw/rtl/dbmp_pkg.sv
// ----------------------------------------------------------------------------
// dbmp_pkg
// Shared types and constants for the debounced button mode panel.
// ----------------------------------------------------------------------------
package dbmp_pkg;

    localparam int BUTTONS           = 4;
    localparam int LIT_BUTTONS       = 3;
    localparam int TIME_BITS_DEFAULT = 32;

    localparam int NOW_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DEB_W      = 8;
    localparam int DUR_W      = 16;
    localparam int LEN_W      = 3;
    localparam int SEL_W      = 3;

    localparam logic [DUR_W-1:0] DEFAULT_FLASH_RESET = 16'd200;
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET      = 8'd20;
    localparam logic [LEN_W-1:0] CYCLE_LEN_MAX       = 3'd4;

    typedef enum logic [1:0] {
        KIND_POLL         = 2'd0,
        KIND_READ_CHANGES = 2'd1,
        KIND_READ_ENCODER = 2'd2,
        KIND_CLEAR_ALL    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_MOMENTARY = 2'd0,
        MODE_TOGGLE    = 2'd1,
        MODE_CYCLE     = 2'd2,
        MODE_FLASH     = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_MODES     = 3'd0,
        CFG_CYCLE_LENGTHS    = 3'd1,
        CFG_FLASH_DURATIONS  = 3'd2,
        CFG_DEFAULT_FLASH_MS = 3'd3,
        CFG_DEBOUNCE_MS      = 3'd4
    } t_cfg_idx;

    localparam logic [SEL_W-1:0] SEL_ENABLED = 3'd0;
    localparam logic [SEL_W-1:0] SEL_OFF     = 3'd1;
    localparam logic [SEL_W-1:0] SEL_SLOT0   = 3'd2;
    localparam logic [SEL_W-1:0] SEL_SLOT1   = 3'd3;

    typedef struct packed {
        logic live;
        logic press;
        logic change;
    } t_db_lane;

    typedef struct packed {
        logic [1:0]       cycle_idx;
        logic             toggle;
        logic [SEL_W-1:0] select;
    } t_mode_lane;

    typedef struct packed {
        logic             any_event;
        logic             int_pending;
        logic [3:0]       event_mask;
        logic [3:0]       change_mask;
        logic             encoder_press;
        logic [3:0]       state_byte;
        logic [3:0]       button_levels;
        logic [SEL_W-1:0] led0_select;
        logic [SEL_W-1:0] led1_select;
        logic [SEL_W-1:0] led2_select;
    } t_result;

endpackage

>>> hw/rtl/dbmp_req_if.sv
// ----------------------------------------------------------------------------
// dbmp_req_if
// Request channel: poll or command with raw pin levels and ms time.
// ----------------------------------------------------------------------------
interface dbmp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  pin_levels;
    logic [31:0] now_ms;

    modport source (output valid, kind, pin_levels, now_ms, input ready);
    modport sink   (input valid, kind, pin_levels, now_ms, output ready);
endinterface

>>> hw/rtl/dbmp_res_if.sv
// ----------------------------------------------------------------------------
// dbmp_res_if
// Result channel: event flags, masks, state and LED selections.
// ----------------------------------------------------------------------------
interface dbmp_res_if;
    logic       valid;
    logic       ready;
    logic       any_event;
    logic       int_pending;
    logic [3:0] event_mask;
    logic [3:0] change_mask;
    logic       encoder_press;
    logic [3:0] state_byte;
    logic [3:0] button_levels;
    logic [2:0] led0_select;
    logic [2:0] led1_select;
    logic [2:0] led2_select;

    modport source (output valid, any_event, int_pending, event_mask, change_mask,
                    encoder_press, state_byte, button_levels, led0_select,
                    led1_select, led2_select, input ready);
    modport sink   (input valid, any_event, int_pending, event_mask, change_mask,
                    encoder_press, state_byte, button_levels, led0_select,
                    led1_select, led2_select, output ready);
endinterface

>>> hw/rtl/dbmp_debounce_lane.sv
// ----------------------------------------------------------------------------
// dbmp_debounce_lane
// Time-based debounce of one button with a restartable candidate.
// ----------------------------------------------------------------------------
module dbmp_debounce_lane #(
    parameter int TIME_BITS = dbmp_pkg::TIME_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_poll,
    input  logic                         i_clear,
    input  logic                         i_raw,
    input  logic [TIME_BITS-1:0]         i_now,
    input  logic [dbmp_pkg::DEB_W-1:0]   i_debounce_ms,
    output dbmp_pkg::t_db_lane           o_lane
);

    logic                 r_cand_valid, n_cand_valid;
    logic                 r_cand_level, n_cand_level;
    logic                 r_live, n_live;
    logic [TIME_BITS-1:0] r_stable_since, n_stable_since;
    logic [TIME_BITS-1:0] elapsed;
    logic                 press, change;

    assign elapsed = i_now - r_stable_since;

    always_comb begin
        n_cand_valid   = r_cand_valid;
        n_cand_level   = r_cand_level;
        n_live         = r_live;
        n_stable_since = r_stable_since;
        press          = 1'b0;
        change         = 1'b0;
        if (i_clear) begin
            n_cand_valid = 1'b0;
            n_live       = 1'b0;
        end else if (i_poll) begin
            if (!r_cand_valid) begin
                n_cand_valid   = 1'b1;
                n_cand_level   = i_raw;
                n_stable_since = i_now;
            end else if (i_raw != r_cand_level) begin
                n_cand_level   = i_raw;
                n_stable_since = i_now;
            end else if (i_raw != r_live &&
                         elapsed >= TIME_BITS'(i_debounce_ms)) begin
                change = 1'b1;
                press  = i_raw;
                n_live = i_raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_valid <= 1'b0;
            r_live       <= 1'b0;
        end else begin
            r_cand_valid <= n_cand_valid;
            r_live       <= n_live;
        end
        r_cand_level   <= n_cand_level;
        r_stable_since <= n_stable_since;
    end

    assign o_lane = '{live: n_live, press: press, change: change};

endmodule

>>> hw/rtl/dbmp_mode_lane.sv
// ----------------------------------------------------------------------------
// dbmp_mode_lane
// Mode logic of one lit button: momentary, cycle, toggle or flash, and its LED select.
// ----------------------------------------------------------------------------
module dbmp_mode_lane #(
    parameter int TIME_BITS = dbmp_pkg::TIME_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_poll,
    input  logic                         i_clear,
    input  logic                         i_press,
    input  logic [TIME_BITS-1:0]         i_now,
    input  dbmp_pkg::t_mode              i_mode,
    input  logic [dbmp_pkg::LEN_W-1:0]   i_cycle_len,
    input  logic [dbmp_pkg::DUR_W-1:0]   i_flash_dur,
    input  logic [dbmp_pkg::DUR_W-1:0]   i_default_flash,
    output dbmp_pkg::t_mode_lane         o_lane
);

    logic [1:0]                     r_cycle_idx, n_cycle_idx;
    logic                           r_toggle, n_toggle;
    logic                           r_flash_on, n_flash_on;
    logic [TIME_BITS-1:0]           r_flash_began, n_flash_began;
    logic [dbmp_pkg::DUR_W-1:0]     dur;
    logic [dbmp_pkg::LEN_W-1:0]     len;
    logic [dbmp_pkg::LEN_W-1:0]     idx_inc;
    logic [TIME_BITS-1:0]           elapsed;
    logic [dbmp_pkg::SEL_W-1:0]     sel;

    assign dur     = (i_flash_dur == '0) ? i_default_flash : i_flash_dur;
    assign len     = (i_cycle_len > dbmp_pkg::CYCLE_LEN_MAX) ? dbmp_pkg::CYCLE_LEN_MAX
                                                             : i_cycle_len;
    assign idx_inc = dbmp_pkg::LEN_W'(r_cycle_idx) + 3'd1;
    assign elapsed = i_now - r_flash_began;

    always_comb begin
        n_cycle_idx   = r_cycle_idx;
        n_toggle      = r_toggle;
        n_flash_on    = r_flash_on;
        n_flash_began = r_flash_began;
        if (i_clear) begin
            n_cycle_idx = '0;
            n_toggle    = 1'b0;
            n_flash_on  = 1'b0;
        end else if (i_poll) begin
            // expiry is checked before this poll's press
            if (r_flash_on && elapsed >= TIME_BITS'(dur)) begin
                n_flash_on = 1'b0;
            end
            if (i_press) begin
                case (i_mode)
                    dbmp_pkg::MODE_CYCLE: begin
                        n_cycle_idx = (idx_inc >= len) ? 2'd0 : idx_inc[1:0];
                    end
                    dbmp_pkg::MODE_TOGGLE: begin
                        n_toggle = !r_toggle;
                    end
                    dbmp_pkg::MODE_FLASH: begin
                        n_flash_on    = 1'b1;
                        n_flash_began = i_now;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (i_mode)
            dbmp_pkg::MODE_CYCLE: begin
                sel = (n_cycle_idx == 2'd0) ? dbmp_pkg::SEL_ENABLED
                    : dbmp_pkg::SEL_SLOT0 + dbmp_pkg::SEL_W'(n_cycle_idx);
            end
            dbmp_pkg::MODE_TOGGLE: sel = n_toggle ? dbmp_pkg::SEL_SLOT1
                                                  : dbmp_pkg::SEL_ENABLED;
            dbmp_pkg::MODE_FLASH:  sel = n_flash_on ? dbmp_pkg::SEL_SLOT0
                                                    : dbmp_pkg::SEL_ENABLED;
            default:               sel = dbmp_pkg::SEL_OFF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_idx <= '0;
            r_toggle    <= 1'b0;
            r_flash_on  <= 1'b0;
        end else begin
            r_cycle_idx <= n_cycle_idx;
            r_toggle    <= n_toggle;
            r_flash_on  <= n_flash_on;
        end
        r_flash_began <= n_flash_began;
    end

    assign o_lane = '{cycle_idx: n_cycle_idx, toggle: n_toggle, select: sel};

endmodule

>>> hw/rtl/dbmp_merge.sv
// ----------------------------------------------------------------------------
// dbmp_merge
// Combines lane results into panel flags and masks and forms the result.
// ----------------------------------------------------------------------------
module dbmp_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  dbmp_pkg::t_kind       i_kind,
    input  dbmp_pkg::t_db_lane    i_db   [dbmp_pkg::BUTTONS],
    input  dbmp_pkg::t_mode_lane  i_mode [dbmp_pkg::LIT_BUTTONS],
    output dbmp_pkg::t_result     o_result
);

    logic [dbmp_pkg::BUTTONS-1:0] r_changes, n_changes;
    logic [dbmp_pkg::BUTTONS-1:0] r_events, n_events;
    logic                         r_irq, n_irq;
    logic                         r_encoder, n_encoder;
    logic [dbmp_pkg::BUTTONS-1:0] press_vec, change_vec, live_vec;
    logic                         enc_press;
    logic                         any;

    always_comb begin
        enc_press = 1'b0;
        for (int i = 0; i < dbmp_pkg::BUTTONS; i++) begin
            press_vec[i]  = i_db[i].press;
            change_vec[i] = i_db[i].change;
            live_vec[i]   = i_db[i].live;
            if (i >= dbmp_pkg::LIT_BUTTONS) begin
                enc_press = enc_press | i_db[i].press;
            end
        end
    end

    always_comb begin
        n_changes = r_changes;
        n_events  = r_events;
        n_irq     = r_irq;
        n_encoder = r_encoder;
        any       = 1'b0;
        if (i_accept) begin
            case (i_kind)
                dbmp_pkg::KIND_POLL: begin
                    any       = |press_vec;
                    n_changes = r_changes | change_vec;
                    n_events  = r_events | press_vec;
                    n_irq     = r_irq | any;
                    n_encoder = r_encoder | enc_press;
                end
                dbmp_pkg::KIND_READ_CHANGES: begin
                    n_changes = '0;
                    n_events  = '0;
                    n_irq     = 1'b0;
                end
                dbmp_pkg::KIND_READ_ENCODER: begin
                    n_encoder = 1'b0;
                end
                default: begin
                    n_changes = '0;
                    n_events  = '0;
                    n_irq     = 1'b0;
                    n_encoder = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_changes <= '0;
            r_events  <= '0;
            r_irq     <= 1'b0;
            r_encoder <= 1'b0;
        end else begin
            r_changes <= n_changes;
            r_events  <= n_events;
            r_irq     <= n_irq;
            r_encoder <= n_encoder;
        end
    end

    always_comb begin
        o_result               = '0;
        o_result.any_event     = any;
        o_result.int_pending   = n_irq;
        o_result.event_mask    = n_events;
        // change mask and encoder press are pre-clear on commands, post-update on polls
        o_result.change_mask   = (i_kind == dbmp_pkg::KIND_POLL) ? n_changes : r_changes;
        o_result.encoder_press = (i_kind == dbmp_pkg::KIND_POLL) ? n_encoder : r_encoder;
        o_result.state_byte    = {i_mode[2].toggle, i_mode[1].toggle, i_mode[0].cycle_idx};
        o_result.button_levels = live_vec;
        o_result.led0_select   = i_mode[0].select;
        o_result.led1_select   = i_mode[1].select;
        o_result.led2_select   = i_mode[2].select;
    end

    irq_tracks_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq == (r_events != '0))
        else $error("interrupt flag out of step with event mask");

endmodule

>>> hw/rtl/debounced_button_mode_panel.sv
// ----------------------------------------------------------------------------
// debounced_button_mode_panel
// Four-button debounce panel with per-LED mode logic and color-slot select.
// ----------------------------------------------------------------------------
// Usage: i_req carries one request per handshake: a poll (raw pin levels and
// the ms time) or a command (read/clear change mask, read/clear encoder press,
// clear all). Each accepted request yields exactly one result on o_res.
// Configuration is written on i_cfg_we/i_cfg_index/i_cfg_wdata; the user
// must write it only while idle, not enforced by the block; unknown indexes are ignored.
// Result: registered in the output register, or in the skid register on a stall.
// Throughput: one request per cycle while i_req.ready is high; every lane
// updates its state in the cycle of acceptance, so the next request may follow immediately.
// Output: an output register plus a skid register; i_req.ready is low only
// when both hold results that the receiver has not yet taken. A stalled
// receiver therefore lets at most one further request be accepted.
// Reset: synchronous, active low; clears all flags, debounce candidates and
// mode state, and loads default flash 200 ms and debounce 20 ms.
// ----------------------------------------------------------------------------
module debounced_button_mode_panel #(
    parameter int TIME_BITS = dbmp_pkg::TIME_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dbmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dbmp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    dbmp_req_if.sink                          i_req,
    dbmp_res_if.source                        o_res
);

    localparam int LIT = dbmp_pkg::LIT_BUTTONS;

    logic [2*LIT-1:0]                     r_modes;
    logic [dbmp_pkg::LEN_W*LIT-1:0]       r_cycle_lens;
    logic [dbmp_pkg::DUR_W*LIT-1:0]       r_flash_durs;
    logic [dbmp_pkg::DUR_W-1:0]           r_default_flash;
    logic [dbmp_pkg::DEB_W-1:0]           r_debounce;

    logic                  accept, poll, clear;
    dbmp_pkg::t_kind       kind;
    logic [TIME_BITS-1:0]  now;
    dbmp_pkg::t_db_lane    db_lane   [dbmp_pkg::BUTTONS];
    dbmp_pkg::t_mode_lane  mode_lane [LIT];
    dbmp_pkg::t_result     result;

    dbmp_pkg::t_result     r_out, r_skid;
    logic                  r_out_valid, r_skid_valid;
    logic                  pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes         <= '0;
            r_cycle_lens    <= '0;
            r_flash_durs    <= '0;
            r_default_flash <= dbmp_pkg::DEFAULT_FLASH_RESET;
            r_debounce      <= dbmp_pkg::DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            case (dbmp_pkg::t_cfg_idx'(i_cfg_index))
                dbmp_pkg::CFG_BUTTON_MODES:     r_modes <= i_cfg_wdata[2*LIT-1:0];
                dbmp_pkg::CFG_CYCLE_LENGTHS:
                    r_cycle_lens <= i_cfg_wdata[dbmp_pkg::LEN_W*LIT-1:0];
                dbmp_pkg::CFG_FLASH_DURATIONS:
                    r_flash_durs <= i_cfg_wdata[dbmp_pkg::DUR_W*LIT-1:0];
                dbmp_pkg::CFG_DEFAULT_FLASH_MS:
                    r_default_flash <= i_cfg_wdata[dbmp_pkg::DUR_W-1:0];
                dbmp_pkg::CFG_DEBOUNCE_MS:
                    r_debounce <= i_cfg_wdata[dbmp_pkg::DEB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready = !r_skid_valid;
    assign accept      = i_req.valid && !r_skid_valid;
    assign kind        = dbmp_pkg::t_kind'(i_req.kind);
    assign poll        = accept && (kind == dbmp_pkg::KIND_POLL);
    assign clear       = accept && (kind == dbmp_pkg::KIND_CLEAR_ALL);
    assign now         = i_req.now_ms[TIME_BITS-1:0];

    for (genvar g = 0; g < dbmp_pkg::BUTTONS; g++) begin : g_db
        dbmp_debounce_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_poll        (poll),
            .i_clear       (clear),
            .i_raw         (i_req.pin_levels[g]),
            .i_now         (now),
            .i_debounce_ms (r_debounce),
            .o_lane        (db_lane[g])
        );
    end

    for (genvar g = 0; g < LIT; g++) begin : g_mode
        dbmp_mode_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_poll          (poll),
            .i_clear         (clear),
            .i_press         (db_lane[g].press),
            .i_now           (now),
            .i_mode          (dbmp_pkg::t_mode'(r_modes[2*g +: 2])),
            .i_cycle_len     (r_cycle_lens[dbmp_pkg::LEN_W*g +: dbmp_pkg::LEN_W]),
            .i_flash_dur     (r_flash_durs[dbmp_pkg::DUR_W*g +: dbmp_pkg::DUR_W]),
            .i_default_flash (r_default_flash),
            .o_lane          (mode_lane[g])
        );
    end

    dbmp_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (kind),
        .i_db     (db_lane),
        .i_mode   (mode_lane),
        .o_result (result)
    );

    // output register with skid
    assign pop = r_out_valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : result;
        end
        if (accept && r_out_valid && !pop) begin
            r_skid <= result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.any_event     = r_out.any_event;
    assign o_res.int_pending   = r_out.int_pending;
    assign o_res.event_mask    = r_out.event_mask;
    assign o_res.change_mask   = r_out.change_mask;
    assign o_res.encoder_press = r_out.encoder_press;
    assign o_res.state_byte    = r_out.state_byte;
    assign o_res.button_levels = r_out.button_levels;
    assign o_res.led0_select   = r_out.led0_select;
    assign o_res.led1_select   = r_out.led1_select;
    assign o_res.led2_select   = r_out.led2_select;

    skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed or was dropped");

    event_implies_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.any_event) |-> r_out.int_pending)
        else $error("press event reported without interrupt pending");

endmodule
